/* rtl/hacp_pkg.sv */
// Shared types and constants of the hex ASCII command parser.
package hacp_pkg;

	localparam logic [7:0] CH_V    = 8'h56;
	localparam logic [7:0] CH_W    = 8'h57;
	localparam logic [7:0] CH_L    = 8'h4C;
	localparam logic [7:0] CH_T    = 8'h54;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_9    = 8'h39;
	localparam logic [7:0] CH_A    = 8'h41;
	localparam logic [7:0] CH_F    = 8'h46;
	localparam logic [3:0] HEX_LETTER_OFS = 4'd9;

	localparam logic REG_LOGO_START    = 1'b0;
	localparam logic REG_CAMERA_ENABLE = 1'b1;

	typedef enum logic [2:0] {
		MODE_IDLE     = 3'd0,
		MODE_VOLT_HI  = 3'd1,
		MODE_VOLT_LO  = 3'd2,
		MODE_FP_DATA  = 3'd3,
		MODE_FP_SUM   = 3'd4,
		MODE_CAM_DATA = 3'd5,
		MODE_CAM_SUM  = 3'd6
	} mode_t;

	typedef enum logic [1:0] {
		EV_VOLTAGE = 2'd0,
		EV_BEGIN   = 2'd1,
		EV_BYTE    = 2'd2,
		EV_COMMIT  = 2'd3
	} ev_kind_t;

	typedef struct packed {
		logic [7:0] data;
		logic       is_hex;
		logic [3:0] nibble;
		logic       is_star;
		logic       is_v;
		logic       is_w;
		logic       is_l;
		logic       is_t;
	} class_t;

	typedef struct packed {
		ev_kind_t    kind;
		logic        chan;
		logic [15:0] value;
	} result_t;

endpackage

/* rtl/hex_ascii_command_parser_top.sv */
// Top level of the hex ASCII command parser with its configuration registers.
// An accepted item is written into the middle queue, and any result it yields into the result queue, before it shows.
// Throughput: one item per cycle while neither queue is full; the back stage state machine steps once per item.
// Both queues let input and result sides stall independently without losing items.
// Reset: queues empty, parser idle, logo_start cleared and camera_enable set.
module hex_ascii_command_parser_top #(
	parameter int QUEUE_DEPTH  = 2,
	parameter int RESULT_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  event_kind,
	output logic        channel,
	output logic [15:0] value,
	input  logic        write_en,
	input  logic        reg_index,
	input  logic        write_data
);

	localparam int CLS_W = $bits(hacp_pkg::class_t);
	localparam int RES_W = $bits(hacp_pkg::result_t);

	logic              logo_start_q;
	logic              camera_enable_q;
	logic              mid_full;
	logic              mid_wr;
	logic              mid_empty;
	logic              mid_rd;
	hacp_pkg::class_t  mid_in;
	hacp_pkg::class_t  mid_out;
	logic              res_full;
	logic              res_wr;
	hacp_pkg::result_t res_in;
	hacp_pkg::result_t res_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			logo_start_q    <= 1'b0;
			camera_enable_q <= 1'b1;
		end else if (write_en) begin
			if (reg_index == hacp_pkg::REG_LOGO_START) begin
				logo_start_q <= write_data;
			end
			if (reg_index == hacp_pkg::REG_CAMERA_ENABLE) begin
				camera_enable_q <= write_data;
			end
		end
	end

	hacp_front u_front (
		.push    (push),
		.rx_byte (rx_byte),
		.full    (full),
		.q_full  (mid_full),
		.q_wr    (mid_wr),
		.q_item  (mid_in)
	);

	hacp_fifo #(
		.WIDTH (CLS_W),
		.DEPTH (QUEUE_DEPTH)
	) u_mid_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mid_wr),
		.wr_data (mid_in),
		.full    (mid_full),
		.rd_en   (mid_rd),
		.rd_data (mid_out),
		.empty   (mid_empty)
	);

	hacp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.logo_start    (logo_start_q),
		.camera_enable (camera_enable_q),
		.item_valid    (!mid_empty),
		.item          (mid_out),
		.item_pop      (mid_rd),
		.res_full      (res_full),
		.res_valid     (res_wr),
		.res           (res_in)
	);

	hacp_fifo #(
		.WIDTH (RES_W),
		.DEPTH (RESULT_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_wr),
		.wr_data (res_in),
		.full    (res_full),
		.rd_en   (pop && !empty),
		.rd_data (res_out),
		.empty   (empty)
	);

	assign event_kind = res_out.kind;
	assign channel    = res_out.chan;
	assign value      = res_out.value;

endmodule

/* rtl/hacp_fifo.sv */
// Small register queue used between the parser stages and at the result side.
module hacp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		logic [PW-1:0] n;
		if (p == PW'(DEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + 1'b1;
		end
		return n;
	endfunction

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (rd_en) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/hacp_front.sv */
// Front stage: accepts received bytes and classifies each character.
module hacp_front (
	input  logic             push,
	input  logic [7:0]       rx_byte,
	output logic             full,
	input  logic             q_full,
	output logic             q_wr,
	output hacp_pkg::class_t q_item
);

	logic is_digit;
	logic is_letter;

	assign full      = q_full;
	assign q_wr      = push && !q_full;
	assign is_digit  = (rx_byte >= hacp_pkg::CH_0) && (rx_byte <= hacp_pkg::CH_9);
	assign is_letter = (rx_byte >= hacp_pkg::CH_A) && (rx_byte <= hacp_pkg::CH_F);

	always_comb begin
		q_item.data    = rx_byte;
		q_item.is_hex  = is_digit || is_letter;
		q_item.nibble  = is_letter ? (rx_byte[3:0] + hacp_pkg::HEX_LETTER_OFS) : rx_byte[3:0];
		q_item.is_star = (rx_byte == hacp_pkg::CH_STAR);
		q_item.is_v    = (rx_byte == hacp_pkg::CH_V);
		q_item.is_w    = (rx_byte == hacp_pkg::CH_W);
		q_item.is_l    = (rx_byte == hacp_pkg::CH_L);
		q_item.is_t    = (rx_byte == hacp_pkg::CH_T);
	end

endmodule

/* rtl/hacp_back.sv */
// Back stage: message state machine, checksums and result generation.
module hacp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              logo_start,
	input  logic              camera_enable,
	input  logic              item_valid,
	input  hacp_pkg::class_t  item,
	output logic              item_pop,
	input  logic              res_full,
	output logic              res_valid,
	output hacp_pkg::result_t res
);

	hacp_pkg::mode_t mode_q, mode_d;
	logic            pend_q, pend_d;
	logic [3:0]      nib_q, nib_d;
	logic [7:0]      sum_q, sum_d;
	logic [7:0]      vhi_q, vhi_d;
	logic [7:0]      byte_w;
	logic            chan_w;
	logic            start_fp;

	assign item_pop = item_valid && !res_full;
	assign byte_w   = {nib_q, item.nibble};
	assign chan_w   = (mode_q == hacp_pkg::MODE_CAM_DATA) || (mode_q == hacp_pkg::MODE_CAM_SUM);
	assign start_fp = logo_start ? item.is_l : item.is_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= hacp_pkg::MODE_IDLE;
			pend_q <= 1'b0;
			nib_q  <= '0;
			sum_q  <= '0;
			vhi_q  <= '0;
		end else begin
			mode_q <= mode_d;
			pend_q <= pend_d;
			nib_q  <= nib_d;
			sum_q  <= sum_d;
			vhi_q  <= vhi_d;
		end
	end

	always_comb begin
		mode_d    = mode_q;
		pend_d    = pend_q;
		nib_d     = nib_q;
		sum_d     = sum_q;
		vhi_d     = vhi_q;
		res_valid = 1'b0;
		res.kind  = hacp_pkg::EV_VOLTAGE;
		res.chan  = 1'b0;
		res.value = '0;
		if (item_pop) begin
			unique case (mode_q)
				hacp_pkg::MODE_VOLT_HI: begin
					vhi_d  = item.data;
					mode_d = hacp_pkg::MODE_VOLT_LO;
				end
				hacp_pkg::MODE_VOLT_LO: begin
					res_valid = 1'b1;
					res.kind  = hacp_pkg::EV_VOLTAGE;
					res.value = {vhi_q[6:0], item.data, 1'b0};
					mode_d    = hacp_pkg::MODE_IDLE;
				end
				hacp_pkg::MODE_FP_DATA, hacp_pkg::MODE_CAM_DATA: begin
					if (item.is_star) begin
						pend_d = 1'b0;
						mode_d = chan_w ? hacp_pkg::MODE_CAM_SUM : hacp_pkg::MODE_FP_SUM;
					end else if (!item.is_hex) begin
						mode_d = hacp_pkg::MODE_IDLE;
					end else begin
						if (!chan_w) begin
							sum_d = sum_q + item.data;
						end
						if (!pend_q) begin
							nib_d  = item.nibble;
							pend_d = 1'b1;
						end else begin
							pend_d = 1'b0;
							if (chan_w) begin
								sum_d = sum_q + byte_w;
							end
							res_valid = 1'b1;
							res.kind  = hacp_pkg::EV_BYTE;
							res.chan  = chan_w;
							res.value = {8'h00, byte_w};
						end
					end
				end
				hacp_pkg::MODE_FP_SUM, hacp_pkg::MODE_CAM_SUM: begin
					if (!item.is_hex) begin
						mode_d = hacp_pkg::MODE_IDLE;
					end else if (!pend_q) begin
						nib_d  = item.nibble;
						pend_d = 1'b1;
					end else begin
						pend_d = 1'b0;
						mode_d = hacp_pkg::MODE_IDLE;
						if (byte_w == sum_q) begin
							res_valid = 1'b1;
							res.kind  = hacp_pkg::EV_COMMIT;
							res.chan  = chan_w;
						end
					end
				end
				default: begin
					mode_d = hacp_pkg::MODE_IDLE;
					if (item.is_v) begin
						mode_d = hacp_pkg::MODE_VOLT_HI;
					end else if (start_fp) begin
						pend_d    = 1'b0;
						sum_d     = '0;
						mode_d    = hacp_pkg::MODE_FP_DATA;
						res_valid = 1'b1;
						res.kind  = hacp_pkg::EV_BEGIN;
					end else if (camera_enable && item.is_t) begin
						pend_d    = 1'b0;
						sum_d     = '0;
						mode_d    = hacp_pkg::MODE_CAM_DATA;
						res_valid = 1'b1;
						res.kind  = hacp_pkg::EV_BEGIN;
						res.chan  = 1'b1;
					end
				end
			endcase
		end
	end

	a_res_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> item_pop)
		else $error("result produced without consuming an item");

	a_commit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.kind == hacp_pkg::EV_COMMIT) |-> (res.value == '0))
		else $error("commit item carries a nonzero value");

	a_volt_chan: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.kind == hacp_pkg::EV_VOLTAGE) |-> !res.chan)
		else $error("voltage item on camera channel");

	a_volt_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(item_pop && mode_q == hacp_pkg::MODE_VOLT_HI) |=> (mode_q == hacp_pkg::MODE_VOLT_LO))
		else $error("voltage high byte not followed by low byte state");

endmodule
